@@ rtl/qtbm_pkg.sv @@
// ---------------------------------------------------------------------------
// qtbm_pkg: shared types and constants of the quadtree block mean unit
// Holds the input action codes and the configuration register indexes.
// ---------------------------------------------------------------------------
package qtbm_pkg;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_NEXT = 1'b1;

	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 9;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 8'd1;

	typedef struct packed {
		logic       action;
		logic [7:0] pixel_row;
		logic [7:0] pixel_col;
		logic [7:0] pixel_value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] region_x;
		logic [7:0] region_y;
		logic [8:0] region_width;
		logic [8:0] region_height;
		logic [7:0] mean_gray;
		logic       leaf_flag;
		logic       last_node;
	} out_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_DAT_W-1:0] data;
	} cfg_item_t;

endpackage

@@ rtl/qtbm_if.sv @@
// ---------------------------------------------------------------------------
// qtbm_if: valid/ready channel interfaces
// One interface per payload type, each with source and sink modports.
// ---------------------------------------------------------------------------
interface qtbm_in_if;
	import qtbm_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface qtbm_out_if;
	import qtbm_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface qtbm_cfg_if;
	import qtbm_pkg::*;
	logic      valid;
	logic      ready;
	cfg_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/qtbm_ram.sv @@
// ---------------------------------------------------------------------------
// qtbm_ram: generic single-port synchronous RAM
// One write or one read per cycle; read data registered.
// ---------------------------------------------------------------------------
module qtbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

@@ rtl/quadtree_block_mean_top.sv @@
// ---------------------------------------------------------------------------
// quadtree_block_mean_top: quadtree walk with block mean over a pixel store
// Loads gray pixels into an image RAM and gives one preorder node per request.
// ---------------------------------------------------------------------------
//  Channel   Role    Transaction content
//  in_ch     sink    action, pixel_row, pixel_col, pixel_value
//  out_ch    source  region x/y/width/height, mean_gray, leaf_flag, last_node
//  cfg_ch    sink    register index, 9-bit write data
//
// A pixel load makes one write into the image RAM.
// An internal node goes through stack pop, stack read, decode, then four child
// writes on the single stack port and output.
// A leaf of N pixels makes one image RAM read per pixel, then runs a restoring
// divider of S = AW + 8 bits (24 by default), one quotient bit a cycle.
// Reset clears the control state only; the RAMs are undefined until written.
// A result that is not taken holds the block; the next input waits for it.
module quadtree_block_mean_top #(
	parameter int MAX_ROWS    = 256,
	parameter int MAX_COLS    = 256,
	parameter int LEAF_LIMIT  = 8,
	parameter int STACK_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	qtbm_in_if.sink    in_ch,
	qtbm_out_if.source out_ch,
	qtbm_cfg_if.sink   cfg_ch
);
	import qtbm_pkg::*;

	// Address widths of the image store and the region stack.
	localparam int RW  = $clog2(MAX_ROWS);
	localparam int CW  = $clog2(MAX_COLS);
	localparam int AW  = RW + CW;
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int DW  = SAW + 1;
	// Coordinates and sizes inside the walk; sizes reach the maximum itself.
	localparam int XW  = CW;
	localparam int YW  = RW;
	localparam int WW  = CW + 1;
	localparam int HW  = RW + 1;
	localparam int EW  = XW + YW + WW + HW;
	// Pixel sum and pixel count widths; the divider runs over SUMW quotient bits.
	localparam int SUMW = AW + 8;
	localparam int CNTW = AW + 1;
	localparam int QCW  = $clog2(SUMW + 1);

	typedef struct packed {
		logic [XW-1:0] x;
		logic [YW-1:0] y;
		logic [WW-1:0] w;
		logic [HW-1:0] h;
	} region_t;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_LOAD  = 9'b000000010,
		ST_POP   = 9'b000000100,
		ST_DEC   = 9'b000001000,
		ST_PUSH  = 9'b000010000,
		ST_SUM   = 9'b000100000,
		ST_DIV   = 9'b001000000,
		ST_OUT   = 9'b010000000,
		ST_WAIT  = 9'b100000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [8:0] rows_q, cols_q;
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 9'd256;
			cols_q <= 9'd256;
		end else if (cfg_ch.valid) begin
			if (cfg_ch.data.index == REG_IMAGE_ROWS) begin
				rows_q <= cfg_ch.data.data;
			end else if (cfg_ch.data.index == REG_IMAGE_COLS) begin
				cols_q <= cfg_ch.data.data;
			end
		end
	end

	// Frame size saturated to 1..MAX when the root is taken.
	logic [WW-1:0] root_w;
	logic [HW-1:0] root_h;
	always_comb begin
		if (cols_q == 9'd0) begin
			root_w = WW'(1);
		end else if (32'(cols_q) > 32'(MAX_COLS)) begin
			root_w = WW'(MAX_COLS);
		end else begin
			root_w = WW'(cols_q);
		end
		if (rows_q == 9'd0) begin
			root_h = HW'(1);
		end else if (32'(rows_q) > 32'(MAX_ROWS)) begin
			root_h = HW'(MAX_ROWS);
		end else begin
			root_h = HW'(rows_q);
		end
	end

	// Image RAM.
	logic          img_we;
	logic [AW-1:0] img_addr;
	logic [7:0]    img_wdata, img_rdata;
	qtbm_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_img (
		.clk(clk), .we(img_we), .addr(img_addr), .wdata(img_wdata), .rdata(img_rdata)
	);

	// Region stack RAM.
	logic           stk_we;
	logic [SAW-1:0] stk_addr;
	region_t        stk_wdata, stk_rdata;
	qtbm_ram #(.WIDTH(EW), .DEPTH(1 << SAW)) u_stk (
		.clk(clk), .we(stk_we), .addr(stk_addr), .wdata(stk_wdata), .rdata(stk_rdata)
	);

	// Walk state.
	logic [DW-1:0]  depth_q;
	region_t        cur_q;
	logic           root_q;
	logic [1:0]     push_cnt_q;
	logic [XW-1:0]  ix_q;
	logic [YW-1:0]  iy_q;
	logic           rd_pend_q;
	logic [SUMW-1:0] sum_q, quo_q;
	logic [CNTW-1:0] den_q;
	logic [SUMW-1:0] rem_q;
	logic [QCW-1:0]  qcnt_q;
	in_item_t       item_q;
	out_item_t      res_q;
	logic           res_valid_q;

	logic [WW-1:0] hw_half;
	logic [HW-1:0] hh_half;
	assign hw_half = cur_q.w >> 1;
	assign hh_half = cur_q.h >> 1;

	logic is_leaf;
	assign is_leaf = (cur_q.w <= WW'(LEAF_LIMIT)) || (cur_q.h <= HW'(LEAF_LIMIT))
		|| ((DW+1)'(depth_q) + (DW+1)'(4) > (DW+1)'(STACK_DEPTH));

	// Children are written bottom-right first so the top-left ends on top.
	region_t child;
	always_comb begin
		child = cur_q;
		case (push_cnt_q)
			2'd0: begin
				child.x = cur_q.x + XW'(hw_half);
				child.y = cur_q.y + YW'(hh_half);
				child.w = cur_q.w - hw_half;
				child.h = cur_q.h - hh_half;
			end
			2'd1: begin
				child.y = cur_q.y + YW'(hh_half);
				child.w = hw_half;
				child.h = cur_q.h - hh_half;
			end
			2'd2: begin
				child.x = cur_q.x + XW'(hw_half);
				child.w = cur_q.w - hw_half;
				child.h = hh_half;
			end
			default: begin
				child.w = hw_half;
				child.h = hh_half;
			end
		endcase
	end

	// Last pixel of the raster scan over the leaf.
	logic last_col, last_row;
	assign last_col = (WW'(ix_q) + WW'(1)) == (WW'(cur_q.x) + cur_q.w);
	assign last_row = (HW'(iy_q) + HW'(1)) == (HW'(cur_q.y) + cur_q.h);

	// Restoring divider step.
	logic [SUMW:0] trial;
	assign trial = {rem_q, quo_q[SUMW-1]} - (SUMW+1)'(den_q);

	always_comb begin
		img_we    = 1'b0;
		img_addr  = {iy_q, ix_q};
		img_wdata = item_q.pixel_value;
		if (state_q == ST_LOAD) begin
			img_we    = (RW >= 8 || item_q.pixel_row < 8'(MAX_ROWS))
				&& (CW >= 8 || item_q.pixel_col < 8'(MAX_COLS));
			img_addr  = {RW'(item_q.pixel_row), CW'(item_q.pixel_col)};
		end
		stk_we    = (state_q == ST_PUSH);
		stk_wdata = child;
		stk_addr  = state_q == ST_PUSH ? SAW'(depth_q) : SAW'(depth_q - DW'(1));
	end

	assign in_ch.ready = (state_q == ST_IDLE) && !res_valid_q;
	assign out_ch.valid = res_valid_q;
	assign out_ch.data  = res_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid && in_ch.ready) begin
			item_q <= in_ch.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			depth_q     <= '0;
			res_valid_q <= 1'b0;
			push_cnt_q  <= '0;
			rd_pend_q   <= 1'b0;
			root_q      <= 1'b0;
			qcnt_q      <= '0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						if (in_ch.data.action == ACT_LOAD) begin
							state_q <= ST_LOAD;
						end else begin
							root_q  <= (depth_q == '0) || (depth_q > DW'(STACK_DEPTH));
							state_q <= ST_POP;
						end
					end
				end
				ST_LOAD: state_q <= ST_IDLE;
				ST_POP: begin
					// Stack read issued this cycle unless the root is taken.
					if (root_q) begin
						depth_q <= '0;
					end else begin
						depth_q <= depth_q - DW'(1);
					end
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					if (root_q) begin
						cur_q <= '{x: '0, y: '0, w: root_w, h: root_h};
					end else begin
						cur_q <= stk_rdata;
					end
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					res_q.region_x      <= 8'(cur_q.x);
					res_q.region_y      <= 8'(cur_q.y);
					res_q.region_width  <= 9'(cur_q.w);
					res_q.region_height <= 9'(cur_q.h);
					res_q.mean_gray     <= 8'd0;
					res_q.leaf_flag     <= is_leaf;
					res_q.last_node     <= (depth_q == '0) && is_leaf;
					ix_q       <= cur_q.x;
					iy_q       <= cur_q.y;
					sum_q      <= '0;
					rd_pend_q  <= 1'b1;
					push_cnt_q <= '0;
					den_q      <= CNTW'(cur_q.w) * CNTW'(cur_q.h);
					state_q    <= is_leaf ? ST_SUM : ST_PUSH;
				end
				ST_PUSH: begin
					depth_q    <= depth_q + DW'(1);
					push_cnt_q <= push_cnt_q + 2'd1;
					if (push_cnt_q == 2'd3) begin
						state_q <= ST_OUT;
					end
				end
				ST_SUM: begin
					// Address presented now; data of the previous address arrives.
					// After the last address the final pixel is still to come.
					if (!rd_pend_q) begin
						sum_q <= sum_q + SUMW'(img_rdata);
					end
					rd_pend_q <= last_col && last_row;
					if (last_col) begin
						ix_q <= cur_q.x;
						iy_q <= iy_q + YW'(1);
					end else begin
						ix_q <= ix_q + XW'(1);
					end
					if (last_col && last_row) begin
						state_q <= ST_DIV;
						qcnt_q  <= '0;
					end
				end
				ST_DIV: begin
					if (rd_pend_q) begin
						// Fold in the final pixel and start the divider.
						quo_q     <= sum_q + SUMW'(img_rdata);
						rem_q     <= '0;
						rd_pend_q <= 1'b0;
					end else begin
						if (!trial[SUMW]) begin
							rem_q <= trial[SUMW-1:0];
							quo_q <= {quo_q[SUMW-2:0], 1'b1};
						end else begin
							rem_q <= {rem_q[SUMW-2:0], quo_q[SUMW-1]};
							quo_q <= {quo_q[SUMW-2:0], 1'b0};
						end
						qcnt_q <= qcnt_q + QCW'(1);
						if (qcnt_q == QCW'(SUMW - 1)) begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (res_q.leaf_flag) begin
						res_q.mean_gray <= quo_q[7:0];
					end
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// The stack never holds more entries than it has room for.
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(STACK_DEPTH)) else $error("stack depth overflow");
	// A result is raised only from the output state.
	a_res: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == ST_OUT) else $error("stray result");
	// Last-node results are always leaves.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.last_node |-> res_q.leaf_flag) else $error("bad last node");
`endif
endmodule

@@ tb/tb_qtbm_chan_if.sv @@
// ---------------------------------------------------------------------------
// tb_qtbm_chan_if: channel probes as seen by the testbench
// The block's own valid/ready interfaces are reused unchanged; this file only
// gathers the completion strobes of the three channels for the watchdog.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

interface tb_qtbm_probe_if;
	logic in_fire;
	logic out_fire;
	logic cfg_fire;
endinterface

@@ tb/tb_quadtree_block_mean_top.sv @@
// ---------------------------------------------------------------------------
// tb_quadtree_block_mean_top: self-checking bench for the quadtree block mean
// Loads frames of pixels, walks the quadtree node by node and compares every
// node record against a behavioural walk kept inside the bench.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_quadtree_block_mean_top;
	import qtbm_pkg::*;

	localparam int MAX_ROWS    = 256;
	localparam int MAX_COLS    = 256;
	localparam int LEAF_LIMIT  = 8;
	localparam int STACK_DEPTH = 32;
	localparam int WATCHDOG    = 40000;
	localparam int DRAIN       = 400;

	typedef struct {
		int unsigned x, y, w, h;
	} region_t;

	logic clk;
	logic arst_n;

	qtbm_in_if  in_ch ();
	qtbm_out_if out_ch ();
	qtbm_cfg_if cfg_ch ();
	tb_qtbm_probe_if probe ();

	quadtree_block_mean_top #(
		.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS),
		.LEAF_LIMIT(LEAF_LIMIT), .STACK_DEPTH(STACK_DEPTH)
	) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	// Clock: 10 ns period.
	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// Shadow state of the block: the pixel store, the pending-region stack
	// and the two frame size registers, updated on accepted transactions.
	logic [7:0]  shadow_pixels [0:MAX_ROWS*MAX_COLS-1];
	region_t     walk_stack [0:STACK_DEPTH-1];
	int unsigned walk_depth;
	logic [8:0]  frame_rows;
	logic [8:0]  frame_cols;
	// Pixels already queued for loading; a frame only loads what is missing.
	bit          pixel_queued [0:MAX_ROWS*MAX_COLS-1];

	in_item_t  pending_items [$];
	out_item_t expected_nodes [$];

	int  error_count;
	int  cycle_count;
	int  quiet_cycles;
	bit  all_sent;

	assign probe.in_fire  = in_ch.valid & in_ch.ready;
	assign probe.out_fire = out_ch.valid & out_ch.ready;
	assign probe.cfg_fire = cfg_ch.valid & cfg_ch.ready;

	function automatic int unsigned clamp_dim(logic [8:0] v, int unsigned lim);
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return v;
	endfunction

	// Truncated mean of the gray levels inside a region.
	function automatic int unsigned block_mean(region_t r);
		longint unsigned acc;
		acc = 0;
		for (int unsigned j = r.y; j < r.y + r.h; j++)
			for (int unsigned i = r.x; i < r.x + r.w; i++)
				acc += shadow_pixels[j*MAX_COLS + i];
		return acc / (r.w * r.h);
	endfunction

	// Pops the next region of the preorder walk, pushing its four children
	// when it splits, and forms the node record the block should return.
	function automatic out_item_t next_quad_node();
		region_t     cur;
		region_t     kid;
		out_item_t   node;
		bit          is_leaf;
		int unsigned hw, hh;
		if (walk_depth == 0 || walk_depth > STACK_DEPTH) begin
			// The root picks up the frame size as it stands now.
			walk_stack[0] = '{0, 0, clamp_dim(frame_cols, MAX_COLS),
				clamp_dim(frame_rows, MAX_ROWS)};
			walk_depth = 1;
		end
		walk_depth--;
		cur = walk_stack[walk_depth];
		is_leaf = (cur.w <= LEAF_LIMIT) || (cur.h <= LEAF_LIMIT)
			|| (walk_depth + 4 > STACK_DEPTH);
		node = '0;
		if (is_leaf) begin
			node.mean_gray = 8'(block_mean(cur));
		end else begin
			hw = cur.w / 2;
			hh = cur.h / 2;
			// Pushed in reverse so that top-left comes out first.
			kid = '{cur.x + hw, cur.y + hh, cur.w - hw, cur.h - hh};
			walk_stack[walk_depth++] = kid;
			kid = '{cur.x, cur.y + hh, hw, cur.h - hh};
			walk_stack[walk_depth++] = kid;
			kid = '{cur.x + hw, cur.y, cur.w - hw, hh};
			walk_stack[walk_depth++] = kid;
			kid = '{cur.x, cur.y, hw, hh};
			walk_stack[walk_depth++] = kid;
		end
		node.region_x      = cur.x[7:0];
		node.region_y      = cur.y[7:0];
		node.region_width  = cur.w[8:0];
		node.region_height = cur.h[8:0];
		node.leaf_flag     = is_leaf;
		node.last_node     = (walk_depth == 0);
		return node;
	endfunction

	// Input driver: presents queued items, idling about one cycle in five
	// except in a long calm window where it streams back to back. The
	// shadow state is updated at the edge where the transaction completes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data  <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.data.action == ACT_LOAD)
					shadow_pixels[in_ch.data.pixel_row*MAX_COLS + in_ch.data.pixel_col]
						= in_ch.data.pixel_value;
				else
					expected_nodes.push_back(next_quad_node());
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_items.size() != 0 &&
						((cycle_count > 2000 && cycle_count < 4000) ||
						$urandom_range(99) >= 20)) begin
					in_ch.valid <= 1'b1;
					in_ch.data  <= pending_items.pop_front();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: compares each node record with the oldest expectation
	// and applies random back-pressure outside the calm window.
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_nodes.size() == 0) begin
					$error("node record with nothing expected: %p", out_ch.data);
					error_count++;
				end else begin
					want = expected_nodes.pop_front();
					if (out_ch.data.region_x !== want.region_x) begin
						$error("region_x: expected %0d, got %0d", want.region_x,
							out_ch.data.region_x);
						error_count++;
					end
					if (out_ch.data.region_y !== want.region_y) begin
						$error("region_y: expected %0d, got %0d", want.region_y,
							out_ch.data.region_y);
						error_count++;
					end
					if (out_ch.data.region_width !== want.region_width) begin
						$error("region_width: expected %0d, got %0d",
							want.region_width, out_ch.data.region_width);
						error_count++;
					end
					if (out_ch.data.region_height !== want.region_height) begin
						$error("region_height: expected %0d, got %0d",
							want.region_height, out_ch.data.region_height);
						error_count++;
					end
					if (out_ch.data.mean_gray !== want.mean_gray) begin
						$error("mean_gray: expected %0d, got %0d", want.mean_gray,
							out_ch.data.mean_gray);
						error_count++;
					end
					if (out_ch.data.leaf_flag !== want.leaf_flag) begin
						$error("leaf_flag: expected %0d, got %0d", want.leaf_flag,
							out_ch.data.leaf_flag);
						error_count++;
					end
					if (out_ch.data.last_node !== want.last_node) begin
						$error("last_node: expected %0d, got %0d", want.last_node,
							out_ch.data.last_node);
						error_count++;
					end
				end
			end
			out_ch.ready <= (cycle_count > 2000 && cycle_count < 4000) ||
				($urandom_range(99) >= 20);
		end
	end

	// Watchdog: counts cycles in which no transaction completes on any
	// channel. A healthy run never sits still for anywhere near the limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (probe.in_fire || probe.out_fire || probe.cfg_fire)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic queue_load(int unsigned row, int unsigned col, int unsigned value);
		in_item_t it;
		it.action      = ACT_LOAD;
		it.pixel_row   = 8'(row);
		it.pixel_col   = 8'(col);
		it.pixel_value = 8'(value);
		pixel_queued[(row % MAX_ROWS)*MAX_COLS + (col % MAX_COLS)] = 1'b1;
		pending_items.push_back(it);
	endtask

	task automatic queue_next();
		in_item_t it;
		it.action      = ACT_NEXT;
		it.pixel_row   = 8'($urandom_range(255));
		it.pixel_col   = 8'($urandom_range(255));
		it.pixel_value = 8'($urandom_range(255));
		pending_items.push_back(it);
	endtask

	// Loads every missing pixel of a frame so that no walk reads an
	// unwritten one. The extremes of the gray scale are favoured now and then.
	task automatic queue_frame(int unsigned rows, int unsigned cols);
		int unsigned v;
		for (int unsigned r = 0; r < rows; r++)
			for (int unsigned c = 0; c < cols; c++) begin
				if (!pixel_queued[r*MAX_COLS + c]) begin
					case ($urandom_range(7))
						0: v = 0;
						1: v = 255;
						default: v = $urandom_range(255);
					endcase
					queue_load(r, c, v);
				end
			end
	endtask

	// Holds the sender until every queued transaction has gone and every
	// node record has come back, then lets a pixel write settle. Sampling
	// on the falling edge sees the driver's settled state.
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_items.size() != 0 || in_ch.valid || expected_nodes.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	// Register write; only ever called with the block idle.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [8:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= '{index: idx, data: value};
		do @(posedge clk);
		while (!cfg_ch.ready);
		if (idx == REG_IMAGE_ROWS)
			frame_rows = value;
		else
			frame_cols = value;
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_frame(logic [8:0] rows, logic [8:0] cols);
		wait_idle();
		write_reg(REG_IMAGE_ROWS, rows);
		write_reg(REG_IMAGE_COLS, cols);
		queue_frame(clamp_dim(rows, MAX_ROWS), clamp_dim(cols, MAX_COLS));
	endtask

	initial begin
		int unsigned rows, cols, nexts, random_nexts;
		error_count  = 0;
		cycle_count  = 0;
		quiet_cycles = 0;
		walk_depth   = 0;
		frame_rows   = 9'd256;
		frame_cols   = 9'd256;
		cfg_ch.valid = 1'b0;
		cfg_ch.data  = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: a zero-sized frame saturates to one pixel at full white.
		write_reg(REG_IMAGE_ROWS, 9'd0);
		write_reg(REG_IMAGE_COLS, 9'd0);
		queue_load(0, 0, 255);
		queue_next();
		queue_next();

		// A frame that splits once, with odd sizes, walked past its end.
		// Every later frame lies inside it, so no further loads are needed.
		set_frame(9'd11, 9'd13);
		repeat (8) queue_next();

		// The size changes in the middle of a walk; the old walk finishes
		// first and the new size applies from the next root.
		set_frame(9'd9, 9'd9);
		repeat (3) queue_next();
		set_frame(9'd5, 9'd9);
		repeat (8) queue_next();

		// Random phases: mostly well-formed walks over small frames, mixed
		// with stray pixel writes anywhere in the store.
		random_nexts = 0;
		while (random_nexts < 100) begin
			if ($urandom_range(9) != 0) begin
				rows = ($urandom_range(3) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
				cols = ($urandom_range(3) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 8);
				set_frame(9'(rows), 9'(cols));
			end
			nexts = $urandom_range(1, 15);
			for (int k = 0; k < nexts; k++) begin
				if ($urandom_range(99) < 15)
					queue_load($urandom_range(255), $urandom_range(255),
						$urandom_range(255));
				queue_next();
			end
			random_nexts += nexts;
		end

		wait_idle();
		repeat (DRAIN) @(posedge clk);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
